// ===== hdl/glyph_quad_layout_top_assert.svh =====
`ifndef GLYPH_QUAD_LAYOUT_TOP_ASSERT_SVH
`define GLYPH_QUAD_LAYOUT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GQL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GQL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gql_pkg.sv =====
package gql_pkg;

    localparam int GLYPH_ENTRIES = 64;
    localparam int IDX_W = $clog2(GLYPH_ENTRIES);
    localparam int PTR_W = $clog2(GLYPH_ENTRIES + 1);

    localparam int CMD_W = 2;
    localparam int ENTRY_INDEX_W = 6;
    localparam int CP_W = 21;
    localparam int COORD_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int EXT_IDX_W = ((IDX_W > ENTRY_INDEX_W) ? IDX_W : ENTRY_INDEX_W) + 1;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STEP = 2'd2;

    localparam logic [COORD_W-1:0] LINE_STEP_RESET = 16'd16;
    localparam logic [CP_W-1:0] NEWLINE_CP = 21'h00000A;

    typedef struct packed {
        logic [COORD_W-1:0] offset_x;
        logic [COORD_W-1:0] offset_y;
        logic [COORD_W-1:0] glyph_width;
        logic [COORD_W-1:0] glyph_height;
        logic [COORD_W-1:0] step_x;
        logic [COORD_W-1:0] uv_left;
        logic [COORD_W-1:0] uv_right;
        logic [COORD_W-1:0] uv_top;
        logic [COORD_W-1:0] uv_bottom;
    } glyph_attr_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [CP_W-1:0]          codepoint;
        glyph_attr_t              attr;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] line_step;
    } pen_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] quad_left;
        logic [COORD_W-1:0] quad_right;
        logic [COORD_W-1:0] quad_down;
        logic [COORD_W-1:0] quad_up;
        logic [COORD_W-1:0] uv_left;
        logic [COORD_W-1:0] uv_right;
        logic [COORD_W-1:0] uv_down;
        logic [COORD_W-1:0] uv_up;
        logic [COORD_W-1:0] pen_x_after;
        logic [COORD_W-1:0] pen_y_now;
    } quad_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [CP_W-1:0]  data;
    } cp_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        glyph_attr_t      data;
    } attr_wr_t;

    typedef struct packed {
        logic               clearing;
        logic [COORD_W-1:0] pen_x;
        logic [COORD_W-1:0] pen_y;
    } ctrl_status_t;

endpackage

// ===== hdl/gql_cp_store.sv =====
module gql_cp_store (
    input  logic                  aclk,
    input  gql_pkg::cp_wr_t       wr,
    input  gql_pkg::mem_rd_t      rd,
    output logic [gql_pkg::CP_W-1:0] rd_data
);
    import gql_pkg::*;

    logic [CP_W-1:0] mem [GLYPH_ENTRIES];
    logic [CP_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/gql_attr_store.sv =====
module gql_attr_store (
    input  logic                 aclk,
    input  gql_pkg::attr_wr_t    wr,
    input  gql_pkg::mem_rd_t     rd,
    output gql_pkg::glyph_attr_t rd_data
);
    import gql_pkg::*;

    glyph_attr_t mem [GLYPH_ENTRIES];
    glyph_attr_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/gql_ctrl.sv =====
module gql_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  gql_pkg::item_t            s_item,
    input  gql_pkg::pen_cfg_t         cfg,
    output logic                      m_valid,
    input  logic                      m_ready,
    output gql_pkg::quad_t            m_quad,
    output gql_pkg::cp_wr_t           cp_wr,
    output gql_pkg::mem_rd_t          cp_rd,
    input  logic [gql_pkg::CP_W-1:0]  cp_rd_data,
    output gql_pkg::attr_wr_t         attr_wr,
    output gql_pkg::mem_rd_t          attr_rd,
    input  gql_pkg::glyph_attr_t      attr_rd_data,
    output gql_pkg::ctrl_status_t     status
);
    import gql_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   clr_ptr_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   cur_idx_reg;
    logic [CP_W-1:0]    cp_key_reg;
    logic [COORD_W-1:0] pen_x_reg;
    logic [COORD_W-1:0] pen_y_reg;
    logic               m_valid_reg;
    quad_t              quad_reg;

    logic                 accept;
    logic                 load_en;
    logic [EXT_IDX_W-1:0] ext_idx;
    logic                 in_range;
    logic                 issue;
    logic                 cp_zero;
    logic                 cp_hit;
    logic                 out_free;
    quad_t                quad_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign ext_idx  = EXT_IDX_W'(s_item.entry_index);
    assign in_range = ext_idx < EXT_IDX_W'(GLYPH_ENTRIES);
    assign load_en  = accept && (s_item.command == CMD_LOAD) && in_range;

    assign issue   = (state_reg == ST_SEARCH) && (ptr_reg < PTR_W'(GLYPH_ENTRIES));
    assign cp_zero = (cp_rd_data == '0);
    assign cp_hit  = pend_reg && !cp_zero && (cp_rd_data == cp_key_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            cp_wr.en   = 1'b1;
            cp_wr.addr = clr_ptr_reg;
            cp_wr.data = '0;
        end else begin
            cp_wr.en   = load_en;
            cp_wr.addr = ext_idx[IDX_W-1:0];
            cp_wr.data = s_item.codepoint;
        end
        attr_wr.en   = load_en;
        attr_wr.addr = ext_idx[IDX_W-1:0];
        attr_wr.data = s_item.attr;
        cp_rd.en     = issue;
        cp_rd.addr   = ptr_reg[IDX_W-1:0];
        attr_rd.en   = (state_reg == ST_SEARCH) && cp_hit;
        attr_rd.addr = cur_idx_reg;
    end

    always_comb begin
        quad_next.quad_left   = pen_x_reg + attr_rd_data.offset_x;
        quad_next.quad_right  = quad_next.quad_left + attr_rd_data.glyph_width;
        quad_next.quad_down   = pen_y_reg - attr_rd_data.offset_y;
        quad_next.quad_up     = quad_next.quad_down - attr_rd_data.glyph_height;
        quad_next.uv_left     = attr_rd_data.uv_left;
        quad_next.uv_right    = attr_rd_data.uv_right;
        quad_next.uv_down     = attr_rd_data.uv_top;
        quad_next.uv_up       = attr_rd_data.uv_bottom;
        quad_next.pen_x_after = pen_x_reg + attr_rd_data.step_x;
        quad_next.pen_y_now   = pen_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_ptr_reg <= clr_ptr_reg + 1'b1;
                    if (clr_ptr_reg == IDX_W'(GLYPH_ENTRIES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        unique case (s_item.command)
                            CMD_RESTART: begin
                                pen_x_reg <= cfg.start_x;
                                pen_y_reg <= cfg.start_y;
                            end
                            CMD_DRAW: begin
                                if (s_item.codepoint == NEWLINE_CP) begin
                                    pen_x_reg <= cfg.start_x;
                                    pen_y_reg <= pen_y_reg + cfg.line_step;
                                end else if (s_item.codepoint != '0) begin
                                    cp_key_reg <= s_item.codepoint;
                                    ptr_reg    <= PTR_W'(1);
                                    pend_reg   <= 1'b0;
                                    state_reg  <= ST_SEARCH;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SEARCH: begin
                    pend_reg <= issue;
                    if (issue) begin
                        ptr_reg     <= ptr_reg + 1'b1;
                        cur_idx_reg <= ptr_reg[IDX_W-1:0];
                    end
                    priority if (pend_reg && cp_zero) begin
                        state_reg <= ST_IDLE;
                    end else if (cp_hit) begin
                        state_reg <= ST_EMIT;
                    end else if (!issue) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        quad_reg    <= quad_next;
                        m_valid_reg <= 1'b1;
                        pen_x_reg   <= quad_next.pen_x_after;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_quad          = quad_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.pen_x    = pen_x_reg;
    assign status.pen_y    = pen_y_reg;
endmodule

// ===== hdl/glyph_quad_layout_top.sv =====
// Channel  Direction  Handshake              Beat
// s_       in         s_valid / s_ready      one command with glyph fields
// m_       out        m_valid / m_ready      one screen quad
// cfg_     in         cfg_valid / cfg_ready  one register write
//
// Load, restart and newline are finished when accepted and leave s_ready high.
// A draw reads the codepoint memory one entry per cycle from slot 1 upward; the search
// ends at a hit, at a zero entry or after the last slot, and only a hit emits a quad.
// After reset a clearing pass zeroes every entry of the codepoint memory;
// s_ready stays low meanwhile.
// A quad waiting in the output register does not stall input; only the next hit waits.
module glyph_quad_layout_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gql_pkg::CMD_W-1:0]           s_command,
    input  logic [gql_pkg::ENTRY_INDEX_W-1:0]   s_entry_index,
    input  logic [gql_pkg::CP_W-1:0]            s_codepoint,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_offset_x,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_offset_y,
    input  logic [gql_pkg::COORD_W-1:0]         s_glyph_width,
    input  logic [gql_pkg::COORD_W-1:0]         s_glyph_height,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_step_x,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_uv_left,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_uv_right,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_uv_top,
    input  logic signed [gql_pkg::COORD_W-1:0]  s_uv_bottom,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gql_pkg::COORD_W-1:0]  m_quad_left,
    output logic signed [gql_pkg::COORD_W-1:0]  m_quad_right,
    output logic signed [gql_pkg::COORD_W-1:0]  m_quad_down,
    output logic signed [gql_pkg::COORD_W-1:0]  m_quad_up,
    output logic signed [gql_pkg::COORD_W-1:0]  m_uv_left,
    output logic signed [gql_pkg::COORD_W-1:0]  m_uv_right,
    output logic signed [gql_pkg::COORD_W-1:0]  m_uv_down,
    output logic signed [gql_pkg::COORD_W-1:0]  m_uv_up,
    output logic signed [gql_pkg::COORD_W-1:0]  m_pen_x_after,
    output logic signed [gql_pkg::COORD_W-1:0]  m_pen_y_now,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gql_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gql_pkg::COORD_W-1:0]         cfg_data
);
    import gql_pkg::*;

    `include "glyph_quad_layout_top_assert.svh"

    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] start_y_reg;
    logic [COORD_W-1:0] line_step_reg;

    item_t        s_item;
    pen_cfg_t     cfg;
    quad_t        m_quad;
    cp_wr_t       cp_wr;
    mem_rd_t      cp_rd;
    logic [CP_W-1:0] cp_rd_data;
    attr_wr_t     attr_wr;
    mem_rd_t      attr_rd;
    glyph_attr_t  attr_rd_data;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            line_step_reg <= LINE_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_X:   start_x_reg   <= cfg_data;
                CFG_START_Y:   start_y_reg   <= cfg_data;
                CFG_LINE_STEP: line_step_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.start_x   = start_x_reg;
    assign cfg.start_y   = start_y_reg;
    assign cfg.line_step = line_step_reg;

    assign s_item.command           = s_command;
    assign s_item.entry_index       = s_entry_index;
    assign s_item.codepoint         = s_codepoint;
    assign s_item.attr.offset_x     = s_offset_x;
    assign s_item.attr.offset_y     = s_offset_y;
    assign s_item.attr.glyph_width  = s_glyph_width;
    assign s_item.attr.glyph_height = s_glyph_height;
    assign s_item.attr.step_x       = s_step_x;
    assign s_item.attr.uv_left      = s_uv_left;
    assign s_item.attr.uv_right     = s_uv_right;
    assign s_item.attr.uv_top       = s_uv_top;
    assign s_item.attr.uv_bottom    = s_uv_bottom;

    gql_cp_store u_cp_store (
        .aclk    (aclk),
        .wr      (cp_wr),
        .rd      (cp_rd),
        .rd_data (cp_rd_data)
    );

    gql_attr_store u_attr_store (
        .aclk    (aclk),
        .wr      (attr_wr),
        .rd      (attr_rd),
        .rd_data (attr_rd_data)
    );

    gql_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .cfg          (cfg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_quad       (m_quad),
        .cp_wr        (cp_wr),
        .cp_rd        (cp_rd),
        .cp_rd_data   (cp_rd_data),
        .attr_wr      (attr_wr),
        .attr_rd      (attr_rd),
        .attr_rd_data (attr_rd_data),
        .status       (status)
    );

    assign m_quad_left   = m_quad.quad_left;
    assign m_quad_right  = m_quad.quad_right;
    assign m_quad_down   = m_quad.quad_down;
    assign m_quad_up     = m_quad.quad_up;
    assign m_uv_left     = m_quad.uv_left;
    assign m_uv_right    = m_quad.uv_right;
    assign m_uv_down     = m_quad.uv_down;
    assign m_uv_up       = m_quad.uv_up;
    assign m_pen_x_after = m_quad.pen_x_after;
    assign m_pen_y_now   = m_quad.pen_y_now;

    // No command may reach the tables while the codepoint table is still being zeroed.
    `GQL_ASSERT_NOW(a_no_accept_clearing, aclk, aresetn, status.clearing, !s_ready, "accept during clear")
    // A new quad leaves the pen x at its advanced position.
    `GQL_ASSERT_NOW(a_pen_x_tracks, aclk, aresetn, $rose(m_valid), status.pen_x == m_pen_x_after, "pen x mismatch")
    // A new quad reports the pen y that is still current.
    `GQL_ASSERT_NOW(a_pen_y_tracks, aclk, aresetn, $rose(m_valid), status.pen_y == m_pen_y_now, "pen y mismatch")
endmodule

// ===== verif/glyph_quad_layout_top_tb.sv =====
`timescale 1ns / 100ps

module glyph_quad_layout_top_tb;
    import gql_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam int SETTLE_CYCLES = GLYPH_ENTRIES + 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 40;
    localparam int QUAD_FIELDS = 10;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_command = '0;
    logic [ENTRY_INDEX_W-1:0] s_entry_index = '0;
    logic [CP_W-1:0] s_codepoint = '0;
    logic [COORD_W-1:0] s_offset_x = '0;
    logic [COORD_W-1:0] s_offset_y = '0;
    logic [COORD_W-1:0] s_glyph_width = '0;
    logic [COORD_W-1:0] s_glyph_height = '0;
    logic [COORD_W-1:0] s_step_x = '0;
    logic [COORD_W-1:0] s_uv_left = '0;
    logic [COORD_W-1:0] s_uv_right = '0;
    logic [COORD_W-1:0] s_uv_top = '0;
    logic [COORD_W-1:0] s_uv_bottom = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic [COORD_W-1:0] m_quad_left;
    logic [COORD_W-1:0] m_quad_right;
    logic [COORD_W-1:0] m_quad_down;
    logic [COORD_W-1:0] m_quad_up;
    logic [COORD_W-1:0] m_uv_left;
    logic [COORD_W-1:0] m_uv_right;
    logic [COORD_W-1:0] m_uv_down;
    logic [COORD_W-1:0] m_uv_up;
    logic [COORD_W-1:0] m_pen_x_after;
    logic [COORD_W-1:0] m_pen_y_now;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    logic [CP_W-1:0] cp_table [GLYPH_ENTRIES];
    glyph_attr_t attr_table [GLYPH_ENTRIES];
    pen_cfg_t pen_cfg;
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    quad_t quads_due [$];

    int mismatches = 0;
    int cycle_count = 0;
    int in_gap = 0;
    bit offering = 1'b0;
    bit no_idle = 1'b0;
    int long_hold = 0;
    string quad_field_name [QUAD_FIELDS] = '{"quad_left", "quad_right", "quad_down",
        "quad_up", "uv_left", "uv_right", "uv_down", "uv_up",
        "pen_x_after", "pen_y_now"};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    glyph_quad_layout_top uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_entry_index(s_entry_index),
        .s_codepoint(s_codepoint),
        .s_offset_x(s_offset_x),
        .s_offset_y(s_offset_y),
        .s_glyph_width(s_glyph_width),
        .s_glyph_height(s_glyph_height),
        .s_step_x(s_step_x),
        .s_uv_left(s_uv_left),
        .s_uv_right(s_uv_right),
        .s_uv_top(s_uv_top),
        .s_uv_bottom(s_uv_bottom),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_quad_left(m_quad_left),
        .m_quad_right(m_quad_right),
        .m_quad_down(m_quad_down),
        .m_quad_up(m_quad_up),
        .m_uv_left(m_uv_left),
        .m_uv_right(m_uv_right),
        .m_uv_down(m_uv_down),
        .m_uv_up(m_uv_up),
        .m_pen_x_after(m_pen_x_after),
        .m_pen_y_now(m_pen_y_now),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic int pick_idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic int find_glyph_slot(logic [CP_W-1:0] cp);
        if (cp == '0) return 0;
        for (int i = 1; i < GLYPH_ENTRIES; i++) begin
            if (cp_table[i] == '0) return 0;
            if (cp_table[i] == cp) return i;
        end
        return 0;
    endfunction

    function automatic int table_span();
        int n;
        n = 0;
        while (n + 1 < GLYPH_ENTRIES && cp_table[n + 1] != '0) n++;
        return n;
    endfunction

    function automatic void advance_layout(item_t it);
        int slot;
        glyph_attr_t a;
        quad_t q;
        case (it.command)
            CMD_LOAD: begin
                if (it.entry_index < GLYPH_ENTRIES) begin
                    cp_table[it.entry_index] = it.codepoint;
                    attr_table[it.entry_index] = it.attr;
                end
            end
            CMD_RESTART: begin
                pen_x = pen_cfg.start_x;
                pen_y = pen_cfg.start_y;
            end
            CMD_DRAW: begin
                if (it.codepoint == NEWLINE_CP) begin
                    pen_x = pen_cfg.start_x;
                    pen_y = pen_y + pen_cfg.line_step;
                end else begin
                    slot = find_glyph_slot(it.codepoint);
                    if (slot != 0) begin
                        a = attr_table[slot];
                        q.quad_left = pen_x + a.offset_x;
                        q.quad_right = q.quad_left + a.glyph_width;
                        q.quad_down = pen_y - a.offset_y;
                        q.quad_up = q.quad_down - a.glyph_height;
                        q.uv_left = a.uv_left;
                        q.uv_right = a.uv_right;
                        q.uv_down = a.uv_top;
                        q.uv_up = a.uv_bottom;
                        q.pen_x_after = pen_x + a.step_x;
                        q.pen_y_now = pen_y;
                        quads_due.push_back(q);
                        pen_x = q.pen_x_after;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic glyph_attr_t random_attr();
        glyph_attr_t a;
        logic [159:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        a = r[$bits(glyph_attr_t)-1:0];
        return a;
    endfunction

    function automatic logic [CP_W-1:0] random_cp();
        if ($urandom_range(0, 1) == 0) return CP_W'($urandom_range(21'h20, 21'h7E));
        return CP_W'($urandom_range(1, CP_MAX));
    endfunction

    function automatic item_t load_item(int slot, logic [CP_W-1:0] cp, glyph_attr_t a);
        item_t it;
        it.command = CMD_LOAD;
        it.entry_index = ENTRY_INDEX_W'(slot);
        it.codepoint = cp;
        it.attr = a;
        return it;
    endfunction

    function automatic item_t cmd_item(logic [CMD_W-1:0] cmd, logic [CP_W-1:0] cp);
        item_t it;
        logic [191:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = r[$bits(item_t)-1:0];
        it.command = cmd;
        it.codepoint = cp;
        return it;
    endfunction

    task automatic offer_command(item_t it);
        if (in_gap > 0) begin
            if (offering) s_valid <= 1'b0;
            offering = 1'b0;
            repeat (in_gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        offering = 1'b1;
        s_command <= it.command;
        s_entry_index <= it.entry_index;
        s_codepoint <= it.codepoint;
        s_offset_x <= it.attr.offset_x;
        s_offset_y <= it.attr.offset_y;
        s_glyph_width <= it.attr.glyph_width;
        s_glyph_height <= it.attr.glyph_height;
        s_step_x <= it.attr.step_x;
        s_uv_left <= it.attr.uv_left;
        s_uv_right <= it.attr.uv_right;
        s_uv_top <= it.attr.uv_top;
        s_uv_bottom <= it.attr.uv_bottom;
        do @(posedge aclk); while (!s_ready);
        advance_layout(it);
        in_gap = pick_idle_cycles();
    endtask

    task automatic wait_idle();
        if (offering) s_valid <= 1'b0;
        offering = 1'b0;
        if (in_gap == 0) in_gap = 1;
        while (quads_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pen_regs(pen_cfg_t c);
        logic [CFG_IDX_W-1:0] reg_index [3];
        logic [COORD_W-1:0] reg_value [3];
        reg_index = '{CFG_START_X, CFG_START_Y, CFG_LINE_STEP};
        reg_value = '{c.start_x, c.start_y, c.line_step};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[k];
            cfg_data <= reg_value[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        pen_cfg = c;
    endtask

    task automatic load_font(int size);
        for (int k = 1; k <= size; k++) begin
            offer_command(load_item(k, random_cp(), random_attr()));
        end
        if (size + 1 < GLYPH_ENTRIES) begin
            offer_command(load_item(size + 1, '0, random_attr()));
        end
    endtask

    task automatic run_text(int n);
        int sent;
        int kind;
        int len;
        int span;
        int p;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, GLYPH_ENTRIES - 1)
                                                  : $urandom_range(1, 8);
                load_font(len);
                sent += len + 1;
            end else if (kind < 8) begin
                len = $urandom_range(5, 30);
                for (int k = 0; k < len; k++) begin
                    span = table_span();
                    p = $urandom_range(0, 99);
                    if (p < 75 && span > 0) begin
                        offer_command(cmd_item(CMD_DRAW, cp_table[$urandom_range(1, span)]));
                    end else if (p < 85) begin
                        offer_command(cmd_item(CMD_DRAW, NEWLINE_CP));
                    end else if (p < 90) begin
                        offer_command(cmd_item(CMD_RESTART, random_cp()));
                    end else if (p < 96) begin
                        offer_command(cmd_item(CMD_DRAW, random_cp()));
                    end else if (p < 98) begin
                        offer_command(cmd_item(CMD_DRAW, '0));
                    end else begin
                        offer_command(cmd_item(CMD_RESERVED, random_cp()));
                    end
                end
                sent += len;
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    p = $urandom_range(0, 3);
                    if (p == 0) begin
                        offer_command(load_item($urandom_range(0, GLYPH_ENTRIES - 1),
                                                random_cp(), random_attr()));
                    end else if (p == 1) begin
                        offer_command(load_item($urandom_range(0, GLYPH_ENTRIES - 1),
                                                '0, random_attr()));
                    end else if (p == 2) begin
                        offer_command(cmd_item(CMD_DRAW, CP_W'($urandom_range(0, CP_MAX))));
                    end else begin
                        offer_command(cmd_item(CMD_RESERVED,
                                               CP_W'($urandom_range(0, CP_MAX))));
                    end
                end
                sent += len;
            end
        end
    endtask

    task automatic test_directed_glyphs();
        glyph_attr_t hi_attr;
        glyph_attr_t lo_attr;
        hi_attr = '{offset_x: 16'h7FFF, offset_y: 16'h7FFF, glyph_width: 16'hFFFF,
                    glyph_height: 16'hFFFF, step_x: 16'h7FFF, uv_left: 16'h7FFF,
                    uv_right: 16'h7FFF, uv_top: 16'h7FFF, uv_bottom: 16'h7FFF};
        lo_attr = '{offset_x: 16'h8000, offset_y: 16'h8000, glyph_width: 16'h0000,
                    glyph_height: 16'h0000, step_x: 16'h8000, uv_left: 16'h8000,
                    uv_right: 16'h8000, uv_top: 16'h8000, uv_bottom: 16'h8000};
        offer_command(load_item(1, 21'h41, hi_attr));
        offer_command(load_item(2, CP_MAX, lo_attr));
        offer_command(load_item(0, 21'h5A, random_attr()));
        offer_command(load_item(3, NEWLINE_CP, random_attr()));
        offer_command(cmd_item(CMD_DRAW, 21'h41));
        offer_command(cmd_item(CMD_DRAW, CP_MAX));
        offer_command(cmd_item(CMD_DRAW, NEWLINE_CP));
        offer_command(cmd_item(CMD_DRAW, 21'h41));
        offer_command(cmd_item(CMD_DRAW, 21'h5A));
        offer_command(cmd_item(CMD_DRAW, '0));
        offer_command(cmd_item(CMD_DRAW, 21'h42));
        offer_command(cmd_item(CMD_RESERVED, 21'h41));
        offer_command(cmd_item(CMD_DRAW, 21'h41));
        wait_idle();
        write_pen_regs('{start_x: 16'h7FFF, start_y: 16'h8000, line_step: 16'h8000});
        offer_command(cmd_item(CMD_RESTART, '0));
        offer_command(cmd_item(CMD_DRAW, CP_MAX));
        offer_command(cmd_item(CMD_DRAW, NEWLINE_CP));
        offer_command(cmd_item(CMD_DRAW, 21'h41));
        offer_command(load_item(5, 21'h51, hi_attr));
        offer_command(cmd_item(CMD_DRAW, 21'h51));
        offer_command(load_item(4, 21'h41, lo_attr));
        offer_command(cmd_item(CMD_DRAW, 21'h41));
        offer_command(cmd_item(CMD_DRAW, 21'h51));
        offer_command(cmd_item(CMD_RESTART, '0));
    endtask

    task automatic test_full_glyph_table();
        for (int k = 1; k < GLYPH_ENTRIES; k++) begin
            offer_command(load_item(k, CP_W'(21'h100 + k), random_attr()));
        end
        offer_command(cmd_item(CMD_DRAW, CP_W'(21'h100 + GLYPH_ENTRIES - 1)));
        offer_command(cmd_item(CMD_DRAW, CP_W'(21'h100 + GLYPH_ENTRIES)));
        offer_command(cmd_item(CMD_DRAW, 21'h101));
        offer_command(cmd_item(CMD_RESTART, '0));
    endtask

    task automatic test_pen_settings();
        pen_cfg_t settings [5];
        settings[0] = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
        settings[1] = '{16'h8000, 16'h8000, 16'h8000};
        settings[2] = '{16'h0000, 16'h0000, 16'h0000};
        settings[3] = '{16'hFFFF, 16'h0001, 16'hFFFF};
        settings[4].start_x = COORD_W'($urandom);
        settings[4].start_y = COORD_W'($urandom);
        settings[4].line_step = COORD_W'($urandom);
        for (int k = 0; k < 5; k++) begin
            wait_idle();
            write_pen_regs(settings[k]);
            no_idle = (k == 2);
            run_text(100);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        load_font(3);
        no_idle = 1'b1;
        long_hold = LONG_HOLD_CYCLES;
        for (int k = 0; k < 40; k++) begin
            offer_command(cmd_item(CMD_DRAW, cp_table[$urandom_range(1, 3)]));
        end
        no_idle = 1'b0;
        wait_idle();
        for (int k = 0; k < 20; k++) begin
            offer_command(cmd_item(CMD_DRAW, cp_table[$urandom_range(1, 3)]));
        end
    endtask

    task automatic test_random_text();
        for (int k = 0; k < 6; k++) begin
            no_idle = (k == 3);
            run_text(80);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end else begin
                gap = pick_idle_cycles();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : quad_check
        quad_t got;
        quad_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_quad_left, m_quad_right, m_quad_down, m_quad_up, m_uv_left,
                   m_uv_right, m_uv_down, m_uv_up, m_pen_x_after,
                   m_pen_y_now};
            if (quads_due.size() == 0) begin
                report_mismatch($sformatf("quad beat with none expected: %h", got));
            end else begin
                want = quads_due.pop_front();
                for (int f = 0; f < QUAD_FIELDS; f++) begin
                    if (got[COORD_W*(QUAD_FIELDS-f)-1 -: COORD_W]
                            !== want[COORD_W*(QUAD_FIELDS-f)-1 -: COORD_W]) begin
                        report_mismatch($sformatf("%s: got %h, expected %h",
                            quad_field_name[f], got[COORD_W*(QUAD_FIELDS-f)-1 -: COORD_W],
                            want[COORD_W*(QUAD_FIELDS-f)-1 -: COORD_W]));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        foreach (cp_table[i]) begin
            cp_table[i] = '0;
            attr_table[i] = '0;
        end
        pen_x = '0;
        pen_y = '0;
        pen_cfg = '{start_x: '0, start_y: '0, line_step: LINE_STEP_RESET};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_glyphs();
        test_full_glyph_table();
        test_pen_settings();
        test_output_backpressure();
        test_random_text();
        wait_idle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
